FILE: src/rrc_pkg.sv
// Shared constants and types for the rotated rectangle corner block.
package rrc_pkg;

  localparam int unsigned CFG_W   = 24;  // config register width, unsigned Q8.16
  localparam int unsigned COORD_W = 32;  // signed Q16.16 coordinates
  localparam int unsigned HEAD_W  = 16;  // binary angle
  localparam int unsigned ANGLE_W = 32;  // CORDIC angle, 2^32 = one turn
  localparam int unsigned OFS_W   = 26;  // signed offsets, 17 fraction bits
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ATAN_LEN = 24;

  // CORDIC gain in Q2.30
  localparam logic [63:0] GAIN_Q30 = 64'h26DD3B6A;

  // atan(2^-i) in 2^32-per-turn units
  localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [1:0] {
    REG_BODY_WIDTH  = 2'd0,
    REG_BODY_HEIGHT = 2'd1,
    REG_AXLE_LENGTH = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] front_top_x;
    logic signed [COORD_W-1:0] front_top_y;
    logic signed [COORD_W-1:0] rear_top_x;
    logic signed [COORD_W-1:0] rear_top_y;
    logic signed [COORD_W-1:0] rear_bottom_x;
    logic signed [COORD_W-1:0] rear_bottom_y;
    logic signed [COORD_W-1:0] front_bottom_x;
    logic signed [COORD_W-1:0] front_bottom_y;
  } corners_t;

endpackage

FILE: src/rrc_cordic_step.sv
// One registered CORDIC rotation-mode micro-rotation.
module rrc_cordic_step import rrc_pkg::*; #(
  parameter int unsigned STEP = 0,
  parameter int unsigned XW   = 19
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [XW-1:0]      x_i,
  input  logic signed [XW-1:0]      y_i,
  input  logic signed [ANGLE_W-1:0] z_i,
  output logic                      valid_o,
  output logic signed [XW-1:0]      x_o,
  output logic signed [XW-1:0]      y_o,
  output logic signed [ANGLE_W-1:0] z_o
);

  logic signed [XW-1:0]      x_d, y_d;
  logic signed [ANGLE_W-1:0] z_d;
  logic signed [ANGLE_W-1:0] atan_s;
  logic                      valid_q;
  logic signed [XW-1:0]      x_q, y_q;
  logic signed [ANGLE_W-1:0] z_q;

  assign atan_s = $signed(ATAN_TURNS[STEP]);

  always_comb begin
    if (!z_i[ANGLE_W-1]) begin
      x_d = x_i - (y_i >>> STEP);
      y_d = y_i + (x_i >>> STEP);
      z_d = z_i - atan_s;
    end else begin
      x_d = x_i + (y_i >>> STEP);
      y_d = y_i - (x_i >>> STEP);
      z_d = z_i + atan_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

FILE: src/rrc_rotate.sv
// Offset rotation: multiply, combine and round, add pose and saturate (three stages).
module rrc_rotate import rrc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned CW        = 19
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [CW-1:0]      cos_i,
  input  logic signed [CW-1:0]      sin_i,
  input  logic signed [OFS_W-1:0]   front_i,
  input  logic signed [OFS_W-1:0]   rear_i,
  input  logic signed [OFS_W-1:0]   height_i,
  input  logic signed [COORD_W-1:0] pose_x_i,
  input  logic signed [COORD_W-1:0] pose_y_i,
  output logic                      valid_o,
  output corners_t                  corners_o
);

  localparam int unsigned PW = OFS_W + CW;          // product width
  localparam int unsigned SW = PW + 1;              // sum width
  localparam int unsigned RW = SW - FRAC_BITS - 1;  // rounded width
  localparam int unsigned EW = COORD_W + 1;         // pose + offset

  function automatic logic signed [RW-1:0] round_q16(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = v + $signed(SW'(1) << FRAC_BITS);
    t = t >>> (FRAC_BITS + 1);
    return t[RW-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_add(input logic signed [COORD_W-1:0] p,
                                                        input logic signed [RW-1:0] r);
    logic signed [EW-1:0] s;
    s = EW'(p) + EW'(r);
    if (s[EW-1] != s[EW-2]) begin
      return s[EW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return s[COORD_W-1:0];
  endfunction

  // stage A: products
  logic                      va_q;
  logic signed [PW-1:0]      fc_q, fs_q, rc_q, rs_q, hc_q, hs_q;
  logic signed [COORD_W-1:0] pxa_q, pya_q;

  always_ff @(posedge clk_i) begin
    fc_q  <= PW'(front_i)  * PW'(cos_i);
    fs_q  <= PW'(front_i)  * PW'(sin_i);
    rc_q  <= PW'(rear_i)   * PW'(cos_i);
    rs_q  <= PW'(rear_i)   * PW'(sin_i);
    hc_q  <= PW'(height_i) * PW'(cos_i);
    hs_q  <= PW'(height_i) * PW'(sin_i);
    pxa_q <= pose_x_i;
    pya_q <= pose_y_i;
  end

  // stage B: combine and round; top corners have dy = -h, bottom dy = +h
  logic                      vb_q;
  logic signed [RW-1:0]      ftx_q, fty_q, rtx_q, rty_q, rbx_q, rby_q, fbx_q, fby_q;
  logic signed [COORD_W-1:0] pxb_q, pyb_q;

  always_ff @(posedge clk_i) begin
    ftx_q <= round_q16(SW'(fc_q) + SW'(hs_q));
    fty_q <= round_q16(SW'(fs_q) - SW'(hc_q));
    rtx_q <= round_q16(SW'(rc_q) + SW'(hs_q));
    rty_q <= round_q16(SW'(rs_q) - SW'(hc_q));
    rbx_q <= round_q16(SW'(rc_q) - SW'(hs_q));
    rby_q <= round_q16(SW'(rs_q) + SW'(hc_q));
    fbx_q <= round_q16(SW'(fc_q) - SW'(hs_q));
    fby_q <= round_q16(SW'(fs_q) + SW'(hc_q));
    pxb_q <= pxa_q;
    pyb_q <= pya_q;
  end

  // stage C: add pose, saturate
  logic     vc_q;
  corners_t corners_q;

  always_ff @(posedge clk_i) begin
    corners_q.front_top_x    <= sat_add(pxb_q, ftx_q);
    corners_q.front_top_y    <= sat_add(pyb_q, fty_q);
    corners_q.rear_top_x     <= sat_add(pxb_q, rtx_q);
    corners_q.rear_top_y     <= sat_add(pyb_q, rty_q);
    corners_q.rear_bottom_x  <= sat_add(pxb_q, rbx_q);
    corners_q.rear_bottom_y  <= sat_add(pyb_q, rby_q);
    corners_q.front_bottom_x <= sat_add(pxb_q, fbx_q);
    corners_q.front_bottom_y <= sat_add(pyb_q, fby_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  assign valid_o   = vc_q;
  assign corners_o = corners_q;

endmodule

FILE: src/rotated_rectangle_corners_top.sv
// Top level: APB config, heading split, CORDIC chain, quadrant fix-up and corner rotation.
// Start reaches done_o via the input register, CORDIC chain, fix-up register and u_rotate.
// Throughput: one request per cycle; the CORDIC is one register stage per micro-rotation.
// busy is never asserted, so a request is taken whenever start is high.
// Reset clears every valid bit in the pipeline and all three config registers to zero.
// Results are strobed by done_o for one cycle; the receiver cannot stall.
module rotated_rectangle_corners_top import rrc_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // APB config port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  // request side
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] pose_x_i,
  input  logic signed [COORD_W-1:0] pose_y_i,
  input  logic [HEAD_W-1:0]         heading_i,
  // result side
  output logic                      done_o,
  output logic signed [COORD_W-1:0] front_top_x_o,
  output logic signed [COORD_W-1:0] front_top_y_o,
  output logic signed [COORD_W-1:0] rear_top_x_o,
  output logic signed [COORD_W-1:0] rear_top_y_o,
  output logic signed [COORD_W-1:0] rear_bottom_x_o,
  output logic signed [COORD_W-1:0] rear_bottom_y_o,
  output logic signed [COORD_W-1:0] front_bottom_x_o,
  output logic signed [COORD_W-1:0] front_bottom_y_o
);

  // cos/sin width: FRAC_BITS fraction bits plus headroom for CORDIC growth and sign
  localparam int unsigned CW  = FRAC_BITS + 3;
  localparam int unsigned LAT = CORDIC_STEPS + 5;
  // start vector x = K rounded half up to FRAC_BITS bits
  localparam logic [63:0] K_FULL =
    (GAIN_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] body_width_q, body_height_q, axle_length_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_width_q  <= '0;
      body_height_q <= '0;
      axle_length_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_BODY_WIDTH:  body_width_q  <= pwdata[CFG_W-1:0];
        REG_BODY_HEIGHT: body_height_q <= pwdata[CFG_W-1:0];
        REG_AXLE_LENGTH: axle_length_q <= pwdata[CFG_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_BODY_WIDTH:  prdata = DATA_W'(body_width_q);
      REG_BODY_HEIGHT: prdata = DATA_W'(body_height_q);
      REG_AXLE_LENGTH: prdata = DATA_W'(axle_length_q);
      default:         prdata = '0;
    endcase
  end

  // Corner offsets with 17 fraction bits: (w+l)/2 and (l-w)/2 need no halving.
  // Kept combinational; config must change only while the pipeline is empty (unchecked).
  logic signed [OFS_W-1:0] front_ofs, rear_ofs, height_ofs;

  assign front_ofs  = $signed(OFS_W'(body_width_q) + OFS_W'(axle_length_q));
  assign rear_ofs   = $signed(OFS_W'(axle_length_q)) - $signed(OFS_W'(body_width_q));
  assign height_ofs = $signed(OFS_W'(body_height_q));

  // ---------------------------------------------------------------------------
  // Input stage: split heading into nearest quadrant and a residual in
  // [-1/8, 1/8) turn; the CORDIC only rotates by the residual.
  // ---------------------------------------------------------------------------
  logic              req_acc;
  logic [HEAD_W-1:0] head_rnd;
  quad_e             quad_d;
  logic [HEAD_W-1:0] resid;

  assign busy     = 1'b0;
  assign req_acc  = start & ~busy;
  assign head_rnd = heading_i + HEAD_W'(16'h2000);
  assign quad_d   = quad_e'(head_rnd[HEAD_W-1:HEAD_W-2]);
  assign resid    = heading_i - {head_rnd[HEAD_W-1:HEAD_W-2], {(HEAD_W-2){1'b0}}};

  logic                      v0_q;
  logic signed [ANGLE_W-1:0] z0_q;

  // pose and quadrant ride alongside the CORDIC stages
  logic signed [COORD_W-1:0] px_q [CORDIC_STEPS+1];
  logic signed [COORD_W-1:0] py_q [CORDIC_STEPS+1];
  quad_e                     quad_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= req_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    z0_q      <= $signed({resid, {(ANGLE_W-HEAD_W){1'b0}}});
    px_q[0]   <= pose_x_i;
    py_q[0]   <= pose_y_i;
    quad_q[0] <= quad_d;
  end

  // ---------------------------------------------------------------------------
  // CORDIC chain, one registered micro-rotation per step
  // ---------------------------------------------------------------------------
  logic                      cv [CORDIC_STEPS+1];
  logic signed [CW-1:0]      cx [CORDIC_STEPS+1];
  logic signed [CW-1:0]      cy [CORDIC_STEPS+1];
  logic signed [ANGLE_W-1:0] cz [CORDIC_STEPS+1];

  assign cv[0] = v0_q;
  assign cx[0] = $signed(K_FULL[CW-1:0]);
  assign cy[0] = '0;
  assign cz[0] = z0_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    rrc_cordic_step #(
      .STEP (i),
      .XW   (CW)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .x_i     (cx[i]),
      .y_i     (cy[i]),
      .z_i     (cz[i]),
      .valid_o (cv[i+1]),
      .x_o     (cx[i+1]),
      .y_o     (cy[i+1]),
      .z_o     (cz[i+1])
    );

    always_ff @(posedge clk_i) begin
      px_q[i+1]   <= px_q[i];
      py_q[i+1]   <= py_q[i];
      quad_q[i+1] <= quad_q[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Quadrant fix-up: exact swap/negate of the CORDIC result
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]      cos_d, sin_d;
  logic                      vq_q;
  logic signed [CW-1:0]      cos_q, sin_q;
  logic signed [COORD_W-1:0] pxq_q, pyq_q;

  always_comb begin
    case (quad_q[CORDIC_STEPS])
      QUAD_0: begin
        cos_d = cx[CORDIC_STEPS];
        sin_d = cy[CORDIC_STEPS];
      end
      QUAD_90: begin
        cos_d = -cy[CORDIC_STEPS];
        sin_d = cx[CORDIC_STEPS];
      end
      QUAD_180: begin
        cos_d = -cx[CORDIC_STEPS];
        sin_d = -cy[CORDIC_STEPS];
      end
      default: begin
        cos_d = cy[CORDIC_STEPS];
        sin_d = -cx[CORDIC_STEPS];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= 1'b0;
    end else begin
      vq_q <= cv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= cos_d;
    sin_q <= sin_d;
    pxq_q <= px_q[CORDIC_STEPS];
    pyq_q <= py_q[CORDIC_STEPS];
  end

  // ---------------------------------------------------------------------------
  // Rotate offsets, add pose, saturate
  // ---------------------------------------------------------------------------
  corners_t corners;

  rrc_rotate #(
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW)
  ) u_rotate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vq_q),
    .cos_i     (cos_q),
    .sin_i     (sin_q),
    .front_i   (front_ofs),
    .rear_i    (rear_ofs),
    .height_i  (height_ofs),
    .pose_x_i  (pxq_q),
    .pose_y_i  (pyq_q),
    .valid_o   (done_o),
    .corners_o (corners)
  );

  assign front_top_x_o    = corners.front_top_x;
  assign front_top_y_o    = corners.front_top_y;
  assign rear_top_x_o     = corners.rear_top_x;
  assign rear_top_y_o     = corners.rear_top_y;
  assign rear_bottom_x_o  = corners.rear_bottom_x;
  assign rear_bottom_y_o  = corners.rear_bottom_y;
  assign front_bottom_x_o = corners.front_bottom_x;
  assign front_bottom_y_o = corners.front_bottom_y;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // every accepted request comes out on done_o at the expected latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> ##LAT done_o)
    else $error("request did not complete at the expected latency");

  // with a zero-size footprint, opposite corners must coincide (all collapse onto the pose)
  a_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && body_width_q == '0 && body_height_q == '0 && axle_length_q == '0) |->
      (front_top_x_o == rear_bottom_x_o && front_top_y_o == rear_bottom_y_o &&
       rear_top_x_o == front_bottom_x_o && rear_top_y_o == front_bottom_y_o))
    else $error("zero footprint gave distinct corners");

endmodule
